/* sv/mgssd_pkg.sv */
// Package for the motion gesture start/stop detector.
// Holds register indexes, reset values, phase codes, the sequencer states and the result type.
// No dependencies.
package mgssd_pkg;

  // Default sizes handed to the top level
  localparam int unsigned HISTORY_DEPTH_DEF = 16;
  localparam int unsigned COORD_BITS_DEF    = 16;

  // Configuration port
  localparam int unsigned CFG_AW = 2;
  localparam int unsigned CFG_DW = 17;

  localparam logic [CFG_AW-1:0] CFG_START_THRESH = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_END_THRESH   = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_END_CHECKS   = 2'd2;
  localparam logic [CFG_AW-1:0] CFG_MISS_LIMIT   = 2'd3;

  // Register widths and reset values
  localparam int unsigned THRW   = 17;
  localparam int unsigned THRSQW = 2 * THRW;
  localparam int unsigned CHKW   = 4;
  localparam int unsigned LIMW   = 8;
  localparam int unsigned MISSW  = 9;

  localparam logic [THRW-1:0] START_THRESH_RST = 17'd8000;
  localparam logic [THRW-1:0] END_THRESH_RST   = 17'd2000;
  localparam logic [CHKW-1:0] END_CHECKS_RST   = 4'd1;
  localparam logic [LIMW-1:0] MISS_LIMIT_RST   = 8'd5;

  // Phase of a frame
  typedef enum logic [1:0] {
    PH_NONE = 2'd0,
    PH_IN   = 2'd1,
    PH_END  = 2'd2
  } phase_t;

  // One result item
  typedef struct packed {
    logic   started;
    phase_t phase;
    logic   active;
  } res_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_EVAL  = 3'd1,
    ST_CHECK = 3'd2,
    ST_SQ1   = 3'd3,
    ST_SQ2   = 3'd4,
    ST_CMP   = 3'd5,
    ST_DONE  = 3'd6
  } state_t;

endpackage

/* sv/mgssd_hist_mem.sv */
// Point history ring storage: one write port, one read port with registered data.
// Standalone; sized by the top level.
module mgssd_hist_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned W     = 49
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [W-1:0]             wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [W-1:0]             rd_data
);

  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rd_data_r;

  // Write the new point
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read every cycle, with the read data registered
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

/* sv/mgssd_sq_len.sv */
// Squared step length between two points, two register stages.
// Stage one squares the coordinate differences, stage two sums them. Standalone.
module mgssd_sq_len #(
  parameter int unsigned CB = 16
) (
  input  logic              clk,
  input  logic [3*CB-1:0]   a_xyz,
  input  logic [3*CB-1:0]   b_xyz,
  output logic [2*CB+1:0]   len_sq
);

  localparam int unsigned SQW  = 2 * CB + 1;
  localparam int unsigned LENW = 2 * CB + 2;

  logic signed [CB:0]     d [3];
  logic signed [2*CB+1:0] p [3];
  logic [SQW-1:0]         sq_r [3];
  logic [LENW-1:0]        len_r;

  // Differences and squares, one lane per axis
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      d[k] = $signed({a_xyz[k*CB+CB-1], a_xyz[k*CB +: CB]})
           - $signed({b_xyz[k*CB+CB-1], b_xyz[k*CB +: CB]});
      p[k] = d[k] * d[k];
    end
  end

  // Stage one: hold the squares
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      sq_r[k] <= p[k][SQW-1:0];
    end
  end

  // Stage two: sum the three axes
  always_ff @(posedge clk) begin
    len_r <= LENW'(sq_r[0]) + LENW'(sq_r[1]) + LENW'(sq_r[2]);
  end

  assign len_sq = len_r;

endmodule

/* sv/motion_gesture_start_stop_detector.sv */
// Motion gesture start/stop detector, top level; uses mgssd_pkg, mgssd_hist_mem, mgssd_sq_len.
// Per item: with under two points or past the miss limit the result goes straight to hand-over;
// a start check reads, squares and compares the newest pair; in a gesture each still step is
// read, squared and compared until enough still steps end it, the history runs out or a step fails.
// One item is taken at a time, only in idle; out_tready holding the output register stalls it.
// Reset (rst_n, synchronous) empties the history, loads defaults.
module motion_gesture_start_stop_detector #(
  parameter int unsigned HISTORY_DEPTH = mgssd_pkg::HISTORY_DEPTH_DEF,
  parameter int unsigned COORD_BITS    = mgssd_pkg::COORD_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // tdata: pos_x, pos_y, pos_z from bit 0 up, zero filled
  input  logic [((3*COORD_BITS+7)/8)*8-1:0]     in_tdata,
  // tuser: pos_valid
  input  logic [0:0]                            in_tuser,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // tdata: active in bit 0, zero filled
  output logic [7:0]                            out_tdata,
  // tuser: phase in bits 1:0, started in bit 2
  output logic [2:0]                            out_tuser,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  input  logic                                  cfg_we,
  input  logic [mgssd_pkg::CFG_AW-1:0]          cfg_addr,
  input  logic [mgssd_pkg::CFG_DW-1:0]          cfg_wdata
);

  import mgssd_pkg::*;

  localparam int unsigned AW   = $clog2(HISTORY_DEPTH);
  localparam int unsigned CNTW = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned PW   = 3 * COORD_BITS + 1;
  localparam int unsigned LENW = 2 * COORD_BITS + 2;
  localparam int unsigned CMPW = (LENW > THRSQW) ? LENW : THRSQW;

  // Configuration registers
  logic [THRW-1:0] start_thresh_r;
  logic [THRW-1:0] end_thresh_r;
  logic [CHKW-1:0] end_checks_r;
  logic [LIMW-1:0] miss_limit_r;

  // Control state
  state_t          state_r, state_nxt;
  logic [AW-1:0]   head_r, head_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  phase_t          phase_r, phase_nxt;
  logic [MISSW-1:0] miss_r, miss_nxt;
  logic            out_valid_r, out_valid_nxt;

  // Work registers
  logic [AW-1:0]     rd_addr_r, rd_addr_nxt;
  logic [PW-1:0]     a_r, a_nxt;
  logic [PW-1:0]     b_r, b_nxt;
  logic [THRSQW-1:0] thr_sq_r, thr_sq_nxt;
  logic [CHKW-1:0]   step_r, step_nxt;
  res_t              res_r, res_nxt;
  res_t              out_res_r, out_res_nxt;

  // Datapath signals
  logic              in_fire;
  logic [PW-1:0]     in_pt;
  logic [PW-1:0]     rd_data;
  logic [LENW-1:0]   len_sq;
  logic [THRW-1:0]   thr_sel;
  logic [THRSQW-1:0] thr_prod;
  logic              gesture;
  logic              len_gt;
  logic              pair_ok;
  logic              chk_end;
  logic              chk_short;
  logic              few_pts;
  logic [MISSW-1:0]  miss_calc;
  logic              miss_over;
  logic              out_free;

  assign in_fire  = in_tvalid && in_tready;
  assign in_pt    = {in_tuser[0], in_tdata[3*COORD_BITS-1:0]};
  assign gesture  = (phase_r == PH_IN);
  assign thr_sel  = gesture ? end_thresh_r : start_thresh_r;
  assign thr_prod = thr_sel * thr_sel;
  assign len_gt   = CMPW'(len_sq) > CMPW'(thr_sq_r);
  assign pair_ok  = a_r[PW-1] && b_r[PW-1];
  assign chk_end  = (step_r == end_checks_r);
  assign chk_short = ((32'(step_r) + 32'd1) >= 32'(cnt_r));
  assign few_pts  = (cnt_r < CNTW'(2));
  assign miss_calc = a_r[PW-1] ? '0 : ((miss_r != '1) ? miss_r + 1'b1 : miss_r);
  assign miss_over = miss_calc > MISSW'(miss_limit_r);
  assign out_free = !out_valid_r || out_tready;

  // History ring
  mgssd_hist_mem #(
    .DEPTH (HISTORY_DEPTH),
    .W     (PW)
  ) u_hist (
    .clk     (clk),
    .wr_en   (in_fire),
    .wr_addr (head_r),
    .wr_data (in_pt),
    .rd_addr (rd_addr_r),
    .rd_data (rd_data)
  );

  // Squared step length between the held pair
  mgssd_sq_len #(
    .CB (COORD_BITS)
  ) u_len (
    .clk    (clk),
    .a_xyz  (a_r[PW-2:0]),
    .b_xyz  (rd_data[PW-2:0]),
    .len_sq (len_sq)
  );

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_thresh_r <= START_THRESH_RST;
      end_thresh_r   <= END_THRESH_RST;
      end_checks_r   <= END_CHECKS_RST;
      miss_limit_r   <= MISS_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_START_THRESH: start_thresh_r <= cfg_wdata[THRW-1:0];
        CFG_END_THRESH:   end_thresh_r   <= cfg_wdata[THRW-1:0];
        CFG_END_CHECKS:   end_checks_r   <= cfg_wdata[CHKW-1:0];
        CFG_MISS_LIMIT:   miss_limit_r   <= cfg_wdata[LIMW-1:0];
        default: ;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        priority if (few_pts)  state_nxt = ST_DONE;
        else if (!gesture)     state_nxt = ST_SQ1;
        else if (miss_over)    state_nxt = ST_DONE;
        else                   state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (chk_end || chk_short) state_nxt = ST_DONE;
        else                      state_nxt = ST_SQ1;
      end
      ST_SQ1: state_nxt = ST_SQ2;
      ST_SQ2: state_nxt = ST_CMP;
      ST_CMP: begin
        if (!gesture || !pair_ok || len_gt) state_nxt = ST_DONE;
        else                                state_nxt = ST_CHECK;
      end
      ST_DONE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and result updates
  always_comb begin
    head_nxt      = head_r;
    cnt_nxt       = cnt_r;
    phase_nxt     = phase_r;
    miss_nxt      = miss_r;
    rd_addr_nxt   = rd_addr_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    thr_sq_nxt    = thr_sq_r;
    step_nxt      = step_r;
    res_nxt       = res_r;
    out_res_nxt   = out_res_r;
    out_valid_nxt = out_tready ? 1'b0 : out_valid_r;
    in_tready     = (state_r == ST_IDLE);

    unique case (state_r)
      ST_IDLE: begin
        // Take the item: store it, count it, point the read at the previous entry
        if (in_fire) begin
          head_nxt    = (head_r == AW'(HISTORY_DEPTH - 1)) ? '0 : head_r + 1'b1;
          cnt_nxt     = (cnt_r < CNTW'(HISTORY_DEPTH)) ? cnt_r + 1'b1 : cnt_r;
          rd_addr_nxt = (head_r == '0) ? AW'(HISTORY_DEPTH - 1) : head_r - 1'b1;
          a_nxt       = in_pt;
          thr_sq_nxt  = thr_prod;
          step_nxt    = '0;
        end
      end
      ST_EVAL: begin
        priority if (few_pts) begin
          res_nxt   = '{started: 1'b0, phase: PH_NONE, active: 1'b0};
          phase_nxt = PH_NONE;
        end else if (gesture) begin
          // Count misses; end outright once past the limit
          miss_nxt = miss_calc;
          if (miss_over) begin
            res_nxt   = '{started: 1'b0, phase: PH_END, active: 1'b1};
            phase_nxt = PH_END;
            cnt_nxt   = CNTW'(1);
            miss_nxt  = '0;
          end
        end else begin
          res_nxt = res_r;
        end
      end
      ST_CHECK: begin
        // All required steps still: end; history too short: carry on
        priority if (chk_end) begin
          res_nxt   = '{started: 1'b0, phase: PH_END, active: 1'b1};
          phase_nxt = PH_END;
          cnt_nxt   = CNTW'(1);
          miss_nxt  = '0;
        end else if (chk_short) begin
          res_nxt   = '{started: 1'b0, phase: PH_IN, active: 1'b1};
          phase_nxt = PH_IN;
        end else begin
          res_nxt = res_r;
        end
      end
      ST_SQ1: begin
        b_nxt = rd_data;
      end
      ST_SQ2: begin
        b_nxt = b_r;
      end
      ST_CMP: begin
        if (!gesture) begin
          // Start check on the newest pair
          if (pair_ok && len_gt) begin
            res_nxt   = '{started: 1'b1, phase: PH_IN, active: 1'b1};
            phase_nxt = PH_IN;
            miss_nxt  = '0;
            cnt_nxt   = CNTW'(2);
          end else begin
            res_nxt   = '{started: 1'b0, phase: PH_NONE, active: 1'b0};
            phase_nxt = PH_NONE;
          end
        end else if (!pair_ok || len_gt) begin
          res_nxt   = '{started: 1'b0, phase: PH_IN, active: 1'b1};
          phase_nxt = PH_IN;
        end else begin
          // Step is still: advance one entry back
          a_nxt       = b_r;
          rd_addr_nxt = (rd_addr_r == '0) ? AW'(HISTORY_DEPTH - 1) : rd_addr_r - 1'b1;
          step_nxt    = step_r + 1'b1;
        end
      end
      ST_DONE: begin
        // Hand the item to the output register once it is free
        if (out_free) begin
          out_res_nxt   = res_r;
          out_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      cnt_r       <= '0;
      phase_r     <= PH_NONE;
      miss_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      cnt_r       <= cnt_nxt;
      phase_r     <= phase_nxt;
      miss_r      <= miss_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    rd_addr_r <= rd_addr_nxt;
    a_r       <= a_nxt;
    b_r       <= b_nxt;
    thr_sq_r  <= thr_sq_nxt;
    step_r    <= step_nxt;
    res_r     <= res_nxt;
    out_res_r <= out_res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_res_r.active};
  assign out_tuser  = {out_res_r.started, out_res_r.phase};

`ifndef ASSERT_OFF
  // An accepted item is evaluated in the next cycle
  a_accept_eval: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == ST_EVAL)
    else $error("accepted item not evaluated");

  // A new result appears only from the hand-over state
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_nxt && (!out_valid_r || out_tready)) |-> state_r == ST_DONE)
    else $error("result loaded outside hand-over");

  // The kept point count never exceeds the ring depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNTW'(HISTORY_DEPTH))
    else $error("point count beyond ring depth");

  // A start mark only comes with an active in-gesture result
  a_start_mark: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_res_r.started) |-> (out_res_r.active && out_res_r.phase == PH_IN))
    else $error("start mark on wrong phase");
`endif

endmodule
